[rtl/tpo_pkg.sv]
// Package for the two-operator phase-modulation oscillator.
// Holds the controller/datapath command types, state encoding and Q31 helpers.
// No dependencies.
package tpo_pkg;

	localparam logic signed [31:0] Q31_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q31_MIN = 32'sh80000000;

	// input item kinds (func field)
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CAR_INC   = 3'd0,
		CFG_MOD_INC   = 3'd1,
		CFG_MOD_DEPTH = 3'd2,
		CFG_CAR_MORPH = 3'd3,
		CFG_MOD_MORPH = 3'd4,
		CFG_CAR_LEVEL = 3'd5,
		CFG_MOD_LEVEL = 3'd6
	} cfg_idx_t;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RDI,
		OP_RDN,
		OP_CAPN,
		OP_MFA,
		OP_MFB,
		OP_MAI,
		OP_MBM,
		OP_FIN,
		OP_MDEP,
		OP_MSPAN,
		OP_OFS,
		OP_PH,
		OP_MLC,
		OP_MLM,
		OP_SUM,
		OP_ADV
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD,
		ST_M_RDI,
		ST_M_RDN,
		ST_M_CAPN,
		ST_M_MFA,
		ST_M_MFB,
		ST_M_MAI,
		ST_M_MBM,
		ST_M_FIN,
		ST_MDEP,
		ST_MSPAN,
		ST_OFS,
		ST_PH,
		ST_C_RDI,
		ST_C_RDN,
		ST_C_CAPN,
		ST_C_MFA,
		ST_C_MFB,
		ST_C_MAI,
		ST_C_MBM,
		ST_C_FIN,
		ST_MLC,
		ST_MLM,
		ST_SUM,
		ST_ADV
	} st_t;

	typedef struct packed {
		dp_op_t op;
		logic   car;   // operator select for table ops: 1 carrier, 0 modulator
		logic   take;  // input transaction this cycle
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic adv_done;
	} dp_sts_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
		logic signed [31:0] r;
		if (s[32] != s[31])
			r = s[32] ? Q31_MIN : Q31_MAX;
		else
			r = s[31:0];
		return r;
	endfunction

	// floor(p / 2^31), saturated
	function automatic logic signed [31:0] q31_of(input logic signed [63:0] p);
		return sat33(p[63:31]);
	endfunction

endpackage

[rtl/two_op_phase_mod_wavetable_osc.sv]
// Top level of the two-operator phase-modulation wavetable oscillator.
// Depends on tpo_pkg, tpo_ctrl, tpo_dp (which holds two tpo_ram tables).
//
// One item is in work at a time. A load transaction (tuser[0]=1) writes one
// table word; it gives no output. A tick transaction (tuser[0]=0) gives one
// sample; then each phase that wrapped has depth*65536-1 taken off it, over
// and over, until both phases are back in range. The tick's length is set by
// the single shared 32x32 multiplier (twelve products per tick, each
// registered) and by the single read port of each table, which reads the two
// interpolation neighbors one after another. A finished sample sits in the
// output register and the next item is taken meanwhile; a tick only waits
// before its final sum if the previous sample was not yet taken.
// Table depth must be a power of two; load addresses are taken modulo it.
// Reading a table entry that was never loaded gives an undefined sample.
module two_op_phase_mod_wavetable_osc import tpo_pkg::*; #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [8:0] table_address, [40:9] table_word, rest zero
	input  logic [1:0]  s_tuser,   // [0] func (1 load), [1] table_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sample_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tpo_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .item_load(s_tuser[0] == FUNC_LOAD), .s_tready, .sts, .cmd
	);

	tpo_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .s_tdata, .s_tuser,
		.cfg_we, .cfg_index, .cfg_data, .m_tvalid, .m_tready, .m_tdata
	);

`ifndef SYNTHESIS
	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while busy");

	// phases are back in range whenever a new item can enter
	a_phase_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> sts.adv_done)
		else $error("phase not wrapped at idle");

	// a sample appears only from the final sum step
	a_out_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.op == OP_SUM))
		else $error("output without sum");
`endif

endmodule

[rtl/tpo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[rtl/tpo_ctrl.sv]
// Sequencer for the oscillator: steps the datapath through load and tick work.
// Depends on tpo_pkg.
module tpo_ctrl import tpo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    item_load,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_d = item_load ? ST_LOAD : ST_M_RDI;
			end
			ST_LOAD:   state_d = ST_IDLE;
			ST_M_RDI:  state_d = ST_M_RDN;
			ST_M_RDN:  state_d = ST_M_CAPN;
			ST_M_CAPN: state_d = ST_M_MFA;
			ST_M_MFA:  state_d = ST_M_MFB;
			ST_M_MFB:  state_d = ST_M_MAI;
			ST_M_MAI:  state_d = ST_M_MBM;
			ST_M_MBM:  state_d = ST_M_FIN;
			ST_M_FIN:  state_d = ST_MDEP;
			ST_MDEP:   state_d = ST_MSPAN;
			ST_MSPAN:  state_d = ST_OFS;
			ST_OFS:    state_d = ST_PH;
			ST_PH:     state_d = ST_C_RDI;
			ST_C_RDI:  state_d = ST_C_RDN;
			ST_C_RDN:  state_d = ST_C_CAPN;
			ST_C_CAPN: state_d = ST_C_MFA;
			ST_C_MFA:  state_d = ST_C_MFB;
			ST_C_MFB:  state_d = ST_C_MAI;
			ST_C_MAI:  state_d = ST_C_MBM;
			ST_C_MBM:  state_d = ST_C_FIN;
			ST_C_FIN:  state_d = ST_MLC;
			ST_MLC:    state_d = ST_MLM;
			ST_MLM:    state_d = ST_SUM;
			ST_SUM: begin
				if (sts.out_free)
					state_d = ST_ADV;
			end
			ST_ADV: begin
				if (sts.adv_done)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '{op: OP_NONE, car: 1'b0, take: 1'b0};
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_LOAD:   cmd.op = OP_LOAD;
			ST_M_RDI:  cmd.op = OP_RDI;
			ST_M_RDN:  cmd.op = OP_RDN;
			ST_M_CAPN: cmd.op = OP_CAPN;
			ST_M_MFA:  cmd.op = OP_MFA;
			ST_M_MFB:  cmd.op = OP_MFB;
			ST_M_MAI:  cmd.op = OP_MAI;
			ST_M_MBM:  cmd.op = OP_MBM;
			ST_M_FIN:  cmd.op = OP_FIN;
			ST_MDEP:   cmd.op = OP_MDEP;
			ST_MSPAN:  cmd.op = OP_MSPAN;
			ST_OFS:    cmd.op = OP_OFS;
			ST_PH:     cmd.op = OP_PH;
			ST_C_RDI:  cmd = '{op: OP_RDI,  car: 1'b1, take: 1'b0};
			ST_C_RDN:  cmd = '{op: OP_RDN,  car: 1'b1, take: 1'b0};
			ST_C_CAPN: cmd = '{op: OP_CAPN, car: 1'b1, take: 1'b0};
			ST_C_MFA:  cmd = '{op: OP_MFA,  car: 1'b1, take: 1'b0};
			ST_C_MFB:  cmd = '{op: OP_MFB,  car: 1'b1, take: 1'b0};
			ST_C_MAI:  cmd = '{op: OP_MAI,  car: 1'b1, take: 1'b0};
			ST_C_MBM:  cmd = '{op: OP_MBM,  car: 1'b1, take: 1'b0};
			ST_C_FIN:  cmd = '{op: OP_FIN,  car: 1'b1, take: 1'b0};
			ST_MLC:    cmd.op = OP_MLC;
			ST_MLM:    cmd.op = OP_MLM;
			ST_SUM:    cmd.op = sts.out_free ? OP_SUM : OP_NONE;
			ST_ADV:    cmd.op = OP_ADV;
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule

[rtl/tpo_dp.sv]
// Datapath: config registers, phases, wavetable RAMs, shared 32x32 multiplier,
// and the output register. Depends on tpo_pkg and tpo_ram.
module tpo_dp import tpo_pkg::*; #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int PW  = AW + 16;
	localparam int PHW = ((PW > 25) ? PW : 25) + 1;
	localparam int OW  = PW + 2;
	localparam logic [PHW-1:0]    SPAN_P = PHW'(TABLE_DEPTH * 65536 - 1);
	localparam logic signed [31:0] SPAN_M = 32'(TABLE_DEPTH * 65536 - 1);

	// captured item
	logic          tsel_q;
	logic [AW-1:0] addr_q;
	logic [31:0]   word_q;

	// configuration
	logic [24:0]        cinc_q, minc_q;
	logic signed [31:0] depth_q;
	logic [30:0]        cmorph_q, mmorph_q, clvl_q, mlvl_q;

	logic [PHW-1:0] cp_q, mp_q;
	logic [PW-1:0]  ph_q;

	logic signed [31:0] ai_q, an_q, bi_q, bn_q, va_q, vb_q, t1_q, modout_q, carout_q;
	logic signed [63:0] prod_q;
	logic signed [OW-1:0] ofs_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic [PW-1:0]      rph;
	logic [AW-1:0]      idx_i, idx_n, raddr;
	logic signed [31:0] frac, morph, inv, da, db, pq, tsh, mul_a, mul_b;
	logic signed [31:0] ra, rb;
	logic               mul_en;
	logic signed [63:0] pm;
	logic signed [31:0] phs;

	assign rph   = cmd.car ? ph_q : mp_q[PW-1:0];
	assign idx_i = rph[PW-1:16];
	assign idx_n = idx_i + 1'b1;
	assign raddr = (cmd.op == OP_RDN) ? idx_n : idx_i;
	assign frac  = {1'b0, rph[15:0], 15'b0};
	assign morph = {1'b0, (cmd.car ? cmorph_q : mmorph_q)};
	assign inv   = Q31_MAX - morph;
	assign da    = sat33(33'(an_q) - 33'(ai_q));
	assign db    = sat33(33'(bn_q) - 33'(bi_q));
	assign pq    = q31_of(prod_q);
	assign tsh   = {{15{pq[31]}}, pq[31:15]};
	assign pm    = prod_q[63] ? (prod_q - 64'sd1) : prod_q;
	assign phs   = 32'($signed({1'b0, cp_q})) + 32'(ofs_q);

	tpo_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_a (
		.clk, .we((cmd.op == OP_LOAD) && !tsel_q), .waddr(addr_q), .wdata(word_q),
		.raddr, .rdata(ra)
	);

	tpo_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_b (
		.clk, .we((cmd.op == OP_LOAD) && tsel_q), .waddr(addr_q), .wdata(word_q),
		.raddr, .rdata(rb)
	);

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (cmd.op)
			OP_MFA:   begin mul_a = frac;     mul_b = da;               end
			OP_MFB:   begin mul_a = frac;     mul_b = db;               end
			OP_MAI:   begin mul_a = va_q;     mul_b = inv;              end
			OP_MBM:   begin mul_a = vb_q;     mul_b = morph;            end
			OP_MDEP:  begin mul_a = modout_q; mul_b = depth_q;          end
			OP_MSPAN: begin mul_a = tsh;      mul_b = SPAN_M;           end
			OP_MLC:   begin mul_a = carout_q; mul_b = {1'b0, clvl_q};   end
			OP_MLM:   begin mul_a = modout_q; mul_b = {1'b0, mlvl_q};   end
			default:  mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.take) begin
			tsel_q <= s_tuser[1];
			addr_q <= AW'(s_tdata[8:0]);
			word_q <= s_tdata[40:9];
		end
		unique case (cmd.op)
			OP_RDN:  begin ai_q <= ra; bi_q <= rb; end
			OP_CAPN: begin an_q <= ra; bn_q <= rb; end
			OP_MFB:  va_q <= sat33(33'(ai_q) + 33'(pq));
			OP_MAI:  vb_q <= sat33(33'(bi_q) + 33'(pq));
			OP_MBM:  t1_q <= pq;
			OP_FIN: begin
				if (cmd.car)
					carout_q <= sat33(33'(t1_q) + 33'(pq));
				else
					modout_q <= sat33(33'(t1_q) + 33'(pq));
			end
			OP_OFS:  ofs_q <= OW'((pm >>> 16) + 64'(pm[15]));
			OP_PH: begin
				if (phs < 0)
					ph_q <= PW'(phs + SPAN_M);
				else if (phs > SPAN_M)
					ph_q <= PW'(phs - SPAN_M);
				else
					ph_q <= PW'(phs);
			end
			OP_MLM:  t1_q <= pq;
			OP_SUM:  out_data_q <= sat33(33'(t1_q) + 33'(pq));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cinc_q      <= 25'd150;
			minc_q      <= 25'd225;
			depth_q     <= '0;
			cmorph_q    <= '0;
			mmorph_q    <= '0;
			clvl_q      <= 31'd1073741823;
			mlvl_q      <= 31'd1073741823;
			cp_q        <= '0;
			mp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CAR_INC:   cinc_q   <= cfg_data[24:0];
					CFG_MOD_INC:   minc_q   <= cfg_data[24:0];
					CFG_MOD_DEPTH: depth_q  <= cfg_data;
					CFG_CAR_MORPH: cmorph_q <= cfg_data[30:0];
					CFG_MOD_MORPH: mmorph_q <= cfg_data[30:0];
					CFG_CAR_LEVEL: clvl_q   <= cfg_data[30:0];
					CFG_MOD_LEVEL: mlvl_q   <= cfg_data[30:0];
					default: ;
				endcase
			end
			out_valid_q <= (cmd.op == OP_SUM) || (out_valid_q && !m_tready);
			if (cmd.op == OP_SUM) begin
				cp_q <= cp_q + PHW'(cinc_q);
				mp_q <= mp_q + PHW'(minc_q);
			end
			if (cmd.op == OP_ADV) begin
				if (cp_q > SPAN_P)
					cp_q <= cp_q - SPAN_P;
				if (mp_q > SPAN_P)
					mp_q <= mp_q - SPAN_P;
			end
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;
	assign sts.adv_done = (cp_q <= SPAN_P) && (mp_q <= SPAN_P);
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;

endmodule
